// ===== src/pdb_pkg.sv =====
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types for the PD balance controller: configuration record, controller
// states, multiplier operand selects and the command and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package pdb_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_DERIV_GAIN   = 3'd1,
      REG_FILTER_ALPHA = 3'd2,
      REG_OUTPUT_LIMIT = 3'd3,
      REG_DEAD_ZONE    = 3'd4
   } reg_index_type;

   localparam logic [14:0] OutputLimitReset = 15'h7FFF;

   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] deriv_gain;
      logic [15:0]        filter_alpha;
      logic [14:0]        output_limit;
      logic [14:0]        dead_zone;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM
   } state_type;

   // operand pair for the shared multiplier
   typedef enum logic [1:0] {
      OP_PROP,
      OP_DERIV,
      OP_ALPHA,
      OP_BETA
   } mul_op_type;

   typedef struct packed {
      logic       load_in;
      mul_op_type mul_op;
      logic       p_load;
      logic       d_load;
      logic       acc_load;
      logic       filt_load;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef enum logic [1:0] {
      DIR_STOP     = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

endpackage

`default_nettype wire

// ===== src/pdb_req_if.sv =====
// ----------------------------------------------------------------------------
// pdb_req_if
// Input channel: one sensor sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] gyro_rate;
   logic signed [15:0] target_angle;

   modport source (output valid, output pitch_angle, output gyro_rate,
                   output target_angle, input ready);
   modport sink (input valid, input pitch_angle, input gyro_rate,
                 input target_angle, output ready);
endinterface

`default_nettype wire

// ===== src/pdb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pdb_rsp_if
// Result channel: one controller output per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] control_out;
   logic [1:0]         direction;
   logic [15:0]        drive_speed;

   modport source (output valid, output control_out, output direction,
                   output drive_speed, input ready);
   modport sink (input valid, input control_out, input direction,
                 input drive_speed, output ready);
endinterface

`default_nettype wire

// ===== src/pdb_csr.sv =====
// ----------------------------------------------------------------------------
// pdb_csr
// Configuration registers behind an APB-style port, zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pdb_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [pdb_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic      [pdb_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output pdb_pkg::cfg_type                       cfg
);

   pdb_pkg::cfg_type      cfg_ff, cfg_in;
   pdb_pkg::reg_index_type index;
   logic                  wr_en;

   assign index      = pdb_pkg::reg_index_type'(csr_paddr[pdb_pkg::CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            pdb_pkg::REG_PROP_GAIN:    cfg_in.prop_gain    = csr_pwdata[15:0];
            pdb_pkg::REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_pwdata[15:0];
            pdb_pkg::REG_FILTER_ALPHA: cfg_in.filter_alpha = csr_pwdata[15:0];
            pdb_pkg::REG_OUTPUT_LIMIT: cfg_in.output_limit = csr_pwdata[14:0];
            pdb_pkg::REG_DEAD_ZONE:    cfg_in.dead_zone    = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         pdb_pkg::REG_PROP_GAIN:    csr_prdata = {16'h0, cfg_ff.prop_gain};
         pdb_pkg::REG_DERIV_GAIN:   csr_prdata = {16'h0, cfg_ff.deriv_gain};
         pdb_pkg::REG_FILTER_ALPHA: csr_prdata = {16'h0, cfg_ff.filter_alpha};
         pdb_pkg::REG_OUTPUT_LIMIT: csr_prdata = {17'h0, cfg_ff.output_limit};
         pdb_pkg::REG_DEAD_ZONE:    csr_prdata = {17'h0, cfg_ff.dead_zone};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= '0;
         cfg_ff.deriv_gain   <= '0;
         cfg_ff.filter_alpha <= '0;
         cfg_ff.output_limit <= pdb_pkg::OutputLimitReset;
         cfg_ff.dead_zone    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdb_ctrl
// Sequencer for the PD step: two gain products, two filter products, then
// the sum, clamp and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  pdb_pkg::status_type      status,
   output pdb_pkg::cmd_type         cmd,
   output pdb_pkg::state_type       fsm_state
);

   pdb_pkg::state_type state_ff, state_in;

   assign fsm_state = state_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdb_pkg::ST_IDLE:  if (req_valid) state_in = pdb_pkg::ST_MUL_P;
         pdb_pkg::ST_MUL_P: state_in = pdb_pkg::ST_MUL_D;
         pdb_pkg::ST_MUL_D: state_in = pdb_pkg::ST_MUL_A;
         pdb_pkg::ST_MUL_A: state_in = pdb_pkg::ST_MUL_B;
         pdb_pkg::ST_MUL_B: state_in = pdb_pkg::ST_SUM;
         pdb_pkg::ST_SUM:   if (status.out_free) state_in = pdb_pkg::ST_IDLE;
         default:           state_in = pdb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_op    = pdb_pkg::OP_PROP;
      case (state_ff)
         pdb_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         pdb_pkg::ST_MUL_P: begin
            cmd.mul_op = pdb_pkg::OP_PROP;
            cmd.p_load = 1'b1;
         end
         pdb_pkg::ST_MUL_D: begin
            cmd.mul_op = pdb_pkg::OP_DERIV;
            cmd.d_load = 1'b1;
         end
         pdb_pkg::ST_MUL_A: begin
            cmd.mul_op   = pdb_pkg::OP_ALPHA;
            cmd.acc_load = 1'b1;
         end
         pdb_pkg::ST_MUL_B: begin
            cmd.mul_op    = pdb_pkg::OP_BETA;
            cmd.filt_load = 1'b1;
         end
         pdb_pkg::ST_SUM: begin
            cmd.out_load = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pdb_datapath.sv =====
// ----------------------------------------------------------------------------
// pdb_datapath
// Shared 17x33 multiplier, product rounding, derivative low-pass state, sum,
// clamp and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  pdb_pkg::cfg_type         cfg,
   input  pdb_pkg::cmd_type         cmd,
   output pdb_pkg::status_type      status,
   input  wire logic signed [15:0]  req_pitch_angle,
   input  wire logic signed [15:0]  req_gyro_rate,
   input  wire logic signed [15:0]  req_target_angle,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [15:0]       rsp_control_out,
   output logic [1:0]               rsp_direction,
   output logic [15:0]              rsp_drive_speed
);

   // product rounded half up to Q8.8, then saturated
   function automatic logic signed [15:0] round_sat(input logic signed [49:0] p);
      logic signed [50:0] t;
      logic signed [42:0] s;
      logic signed [15:0] r;
      t = {p[49], p} + 51'sd128;
      s = t[50:8];
      if (s > 43'sd32767) begin
         r = 16'sh7FFF;
      end else if (s < -43'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   logic signed [16:0] err_ff;
   logic signed [15:0] gyro_ff;
   logic signed [15:0] p_term_ff;
   logic signed [15:0] d_term_ff;
   logic signed [49:0] acc_ff;
   logic signed [31:0] filt_ff, filt_in;

   logic signed [16:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [49:0] prod;
   logic signed [16:0] one_minus_alpha;
   logic signed [51:0] blend;

   logic signed [32:0] filt_rnd;
   logic signed [16:0] filt_q88;
   logic signed [17:0] sum;
   logic signed [17:0] limit_pos, limit_neg;
   logic signed [17:0] clamped;
   logic signed [17:0] abs_val;
   logic [1:0]         dir;
   logic [15:0]        speed;

   logic               rsp_valid_ff;
   logic signed [15:0] control_out_ff;
   logic [1:0]         direction_ff;
   logic [15:0]        drive_speed_ff;

   assign one_minus_alpha = 17'sh10000 - $signed({1'b0, cfg.filter_alpha});

   always_comb begin
      case (cmd.mul_op)
         pdb_pkg::OP_PROP: begin
            mul_a = {cfg.prop_gain[15], cfg.prop_gain};
            mul_b = {{16{err_ff[16]}}, err_ff};
         end
         pdb_pkg::OP_DERIV: begin
            mul_a = {cfg.deriv_gain[15], cfg.deriv_gain};
            mul_b = {{17{gyro_ff[15]}}, gyro_ff};
         end
         pdb_pkg::OP_ALPHA: begin
            mul_a = $signed({1'b0, cfg.filter_alpha});
            mul_b = {filt_ff[31], filt_ff};
         end
         pdb_pkg::OP_BETA: begin
            mul_a = one_minus_alpha;
            mul_b = {{17{d_term_ff[15]}}, d_term_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // alpha*old + (1-alpha)*d*2^16, rounded back to Q8.24
   assign blend = {{2{acc_ff[49]}}, acc_ff} + {prod[35:0], 16'h0000} + 52'sd32768;

   always_comb begin
      if (cfg.filter_alpha == 16'h0000) begin
         filt_in = {d_term_ff, 16'h0000};
      end else begin
         filt_in = blend[47:16];
      end
   end

   assign filt_rnd  = {filt_ff[31], filt_ff} + 33'sd32768;
   assign filt_q88  = filt_rnd[32:16];
   assign sum       = {{2{p_term_ff[15]}}, p_term_ff} + {filt_q88[16], filt_q88};
   assign limit_pos = $signed({3'b000, cfg.output_limit});
   assign limit_neg = -limit_pos;

   always_comb begin
      if (sum > limit_pos) begin
         clamped = limit_pos;
      end else if (sum < limit_neg) begin
         clamped = limit_neg;
      end else begin
         clamped = sum;
      end
   end

   always_comb begin
      if (clamped > 18'sd128) begin
         dir = pdb_pkg::DIR_FORWARD;
      end else if (clamped < -18'sd128) begin
         dir = pdb_pkg::DIR_BACKWARD;
      end else begin
         dir = pdb_pkg::DIR_STOP;
      end
   end

   assign abs_val = clamped[17] ? -clamped : clamped;
   assign speed   = abs_val[15:0] + {1'b0, cfg.dead_zone};

   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         err_ff  <= {req_pitch_angle[15], req_pitch_angle}
                  - {req_target_angle[15], req_target_angle};
         gyro_ff <= req_gyro_rate;
      end
      if (cmd.p_load)   p_term_ff <= round_sat(prod);
      if (cmd.d_load)   d_term_ff <= round_sat(prod);
      if (cmd.acc_load) acc_ff    <= prod;
      if (cmd.out_load) begin
         control_out_ff <= clamped[15:0];
         direction_ff   <= dir;
         drive_speed_ff <= speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.filt_load) filt_ff <= filt_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_control_out = control_out_ff;
   assign rsp_direction   = direction_ff;
   assign rsp_drive_speed = drive_speed_ff;

endmodule

`default_nettype wire

// ===== src/pd_balance_controller.sv =====
// ----------------------------------------------------------------------------
// pd_balance_controller
// PD balance controller with a low-pass filtered derivative term.
// ----------------------------------------------------------------------------
// sequence: an accepted sample steps through MUL_P, MUL_D, MUL_A, MUL_B and SUM,
//   and the result register loads from SUM; SUM waits while the result register
//   still holds an untaken transaction. A new sample is taken only back in IDLE,
//   after the four passes through the single shared multiplier and the sum.
// reset: synchronous; clears the sequencer, the filter state and the result
//   valid, and loads the configuration reset values
`default_nettype none

module pd_balance_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pdb_req_if.sink                                req_chan,
   pdb_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pdb_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [pdb_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic      [pdb_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   pdb_pkg::cfg_type    cfg;
   pdb_pkg::cmd_type    cmd;
   pdb_pkg::status_type status;
   pdb_pkg::state_type  fsm_state;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   pdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .fsm_state (fsm_state)
   );

   pdb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_pitch_angle  (req_chan.pitch_angle),
      .req_gyro_rate    (req_chan.gyro_rate),
      .req_target_angle (req_chan.target_angle),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_control_out  (rsp_chan.control_out),
      .rsp_direction    (rsp_chan.direction),
      .rsp_drive_speed  (rsp_chan.drive_speed)
   );

   // an accepted sample always starts the proportional product next
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> (fsm_state == pdb_pkg::ST_MUL_P))
      else $error("accepted sample did not start the sequence");

   // a new result only appears from the sum step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> ($past(fsm_state) == pdb_pkg::ST_SUM))
      else $error("result raised outside the sum step");

   // no sample is taken while a step is in flight
   assert property (@(posedge clock) disable iff (reset)
      (fsm_state != pdb_pkg::ST_IDLE) |-> !req_ready)
      else $error("input ready while busy");

   // the result register is never overwritten while a transaction is pending
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_chan.valid) |-> rsp_chan.ready)
      else $error("pending result overwritten");

endmodule

`default_nettype wire
